// ----- hdl/multi_server_queue_event_step_core_assert.svh -----
// Assertion helpers for the queue event core.
`ifndef MULTI_SERVER_QUEUE_EVENT_STEP_CORE_ASSERT_SVH
`define MULTI_SERVER_QUEUE_EVENT_STEP_CORE_ASSERT_SVH

// same-cycle implication
`define MSQES_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSQES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/msqes_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package msqes_pkg;

    localparam int N_SERVERS_DEF        = 8;
    localparam int QUEUE_COUNT_BITS_DEF = 16;
    localparam int TIME_BITS_DEF        = 32;

    localparam int TOTAL_W = 19;
    localparam int COUNT_W = 32;

    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_EVENT   = 1'b1;

    localparam logic [1:0] KIND_ARRIVAL   = 2'd0;
    localparam logic [1:0] KIND_DEPARTURE = 2'd1;
    localparam logic [1:0] KIND_RESTART   = 2'd2;

    typedef struct packed {
        logic shift;
        logic clear;
    } ring_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/msqes_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module msqes_cell
    import msqes_pkg::*;
#(
    parameter int QUEUE_COUNT_BITS = QUEUE_COUNT_BITS_DEF,
    parameter int TIME_BITS        = TIME_BITS_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ring_ctrl_t                  ctrl,
    input  wire logic [TIME_BITS-1:0]        in_timer,
    input  wire logic                        in_busy,
    input  wire logic [QUEUE_COUNT_BITS-1:0] in_qlen,
    output logic      [TIME_BITS-1:0]        out_timer,
    output logic                             out_busy,
    output logic      [QUEUE_COUNT_BITS-1:0] out_qlen
);

    logic [TIME_BITS-1:0]        timer_reg;
    logic                        busy_reg;
    logic [QUEUE_COUNT_BITS-1:0] qlen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg <= '0;
            busy_reg  <= 1'b0;
            qlen_reg  <= '0;
        end
        else if (ctrl.clear)
        begin
            timer_reg <= '0;
            busy_reg  <= 1'b0;
            qlen_reg  <= '0;
        end
        else if (ctrl.shift)
        begin
            timer_reg <= in_timer;
            busy_reg  <= in_busy;
            qlen_reg  <= in_qlen;
        end
    end

    assign out_timer = timer_reg;
    assign out_busy  = busy_reg;
    assign out_qlen  = qlen_reg;

endmodule

`default_nettype wire

// ----- hdl/multi_server_queue_event_step_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Handshake            | Words
// ----------+----------------------+---------------------------------------------
// command   | start / busy         | op, arrival_interval, service_time,
//           |                      | random_server
// config    | cfg_wr_en            | cfg_wr_data (dispatch_mode)
// result    | done (1-cycle pulse) | event_kind, server_id, elapsed_step,
//           |                      | sim_time, server_queue_length, total_waiting,
//           |                      | arrivals_total, departures_total, queue_overflow
//
// Restart: result strobed on the next cycle.
// Event: the server ring rotates once past the head cell
// to find the minimum timer and shortest queue, once more to apply the event.
// Result registered and strobed on done the cycle after; a new word may start then.
// Async active-low reset: all servers idle, counters, time and timers zero.
// The receiver cannot stall; results are held until the next one.

module multi_server_queue_event_step_core
    import msqes_pkg::*;
#(
    parameter int N_SERVERS        = N_SERVERS_DEF,
    parameter int QUEUE_COUNT_BITS = QUEUE_COUNT_BITS_DEF,
    parameter int TIME_BITS        = TIME_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                op,
    input  wire logic [31:0]         arrival_interval,
    input  wire logic [31:0]         service_time,
    input  wire logic [2:0]          random_server,
    input  wire logic                cfg_wr_en,
    input  wire logic                cfg_wr_data,
    output logic                     done,
    output logic [1:0]               event_kind,
    output logic [2:0]               server_id,
    output logic [31:0]              elapsed_step,
    output logic [63:0]              sim_time,
    output logic [15:0]              server_queue_length,
    output logic [TOTAL_W-1:0]       total_waiting,
    output logic [COUNT_W-1:0]       arrivals_total,
    output logic [COUNT_W-1:0]       departures_total,
    output logic                     queue_overflow
);

    localparam int IDX_W = (N_SERVERS > 1) ? $clog2(N_SERVERS) : 1;
    localparam int QCB   = QUEUE_COUNT_BITS;
    localparam int TB    = TIME_BITS;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_APPLY = 4'b0100,
        S_FIN   = 4'b1000
    } state_t;

    // ring
    logic [TB-1:0]  cell_timer [N_SERVERS];
    logic           cell_busy  [N_SERVERS];
    logic [QCB-1:0] cell_qlen  [N_SERVERS];
    logic [TB-1:0]  fb_timer;
    logic           fb_busy;
    logic [QCB-1:0] fb_qlen;
    ring_ctrl_t     ring_ctrl;

    logic [TB-1:0]  head_timer;
    logic           head_busy;
    logic [QCB-1:0] head_qlen;

    generate
        for (genvar i = 0; i < N_SERVERS; i++)
        begin : g_cell
            logic [TB-1:0]  in_timer;
            logic           in_busy;
            logic [QCB-1:0] in_qlen;

            if (i == N_SERVERS - 1)
            begin : g_tail
                assign in_timer = fb_timer;
                assign in_busy  = fb_busy;
                assign in_qlen  = fb_qlen;
            end
            else
            begin : g_link
                assign in_timer = cell_timer[i+1];
                assign in_busy  = cell_busy[i+1];
                assign in_qlen  = cell_qlen[i+1];
            end

            msqes_cell #(
                .QUEUE_COUNT_BITS (QCB),
                .TIME_BITS        (TB)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ring_ctrl),
                .in_timer  (in_timer),
                .in_busy   (in_busy),
                .in_qlen   (in_qlen),
                .out_timer (cell_timer[i]),
                .out_busy  (cell_busy[i]),
                .out_qlen  (cell_qlen[i])
            );
        end
    endgenerate

    assign head_timer = cell_timer[0];
    assign head_busy  = cell_busy[0];
    assign head_qlen  = cell_qlen[0];

    // control and run state
    state_t             state_reg,     state_next;
    logic [IDX_W-1:0]   cnt_reg,       cnt_next;
    logic               mode_reg;
    logic [TB-1:0]      arr_timer_reg, arr_timer_next;
    logic [63:0]        time_now_reg,  time_now_next;
    logic [COUNT_W-1:0] arr_cnt_reg,   arr_cnt_next;
    logic [COUNT_W-1:0] dep_cnt_reg,   dep_cnt_next;
    logic [TB-1:0]      a_int_reg,     a_int_next;
    logic [TB-1:0]      s_time_reg,    s_time_next;
    logic [2:0]         rnd_reg,       rnd_next;
    logic [TB-1:0]      min_reg,       min_next;
    logic [QCB-1:0]     best_q_reg,    best_q_next;
    logic [IDX_W-1:0]   best_idx_reg,  best_idx_next;
    logic [TOTAL_W-1:0] sum_reg,       sum_next;
    logic               dep_found_reg, dep_found_next;
    logic [IDX_W-1:0]   res_idx_reg,   res_idx_next;
    logic [QCB-1:0]     res_q_reg,     res_q_next;
    logic               ovf_reg,       ovf_next;

    // result words
    logic               done_reg,      done_next;
    logic [1:0]         kind_reg,      kind_next;
    logic [2:0]         sidx_reg,      sidx_next;
    logic [31:0]        elapsed_reg,   elapsed_next;
    logic [63:0]        simt_reg,      simt_next;
    logic [15:0]        sqlen_reg,     sqlen_next;
    logic [TOTAL_W-1:0] total_reg,     total_next;
    logic [COUNT_W-1:0] arr_out_reg,   arr_out_next;
    logic [COUNT_W-1:0] dep_out_reg,   dep_out_next;
    logic               qovf_reg,      qovf_next;

    logic               last_pos;
    logic               arr_hit;
    logic [6:0]         rnd_mod;
    logic [IDX_W-1:0]   target;
    logic [64:0]        time_sum;
    logic [63:0]        time_sat;
    logic [QCB-1:0]     q_dec;

    assign last_pos = (cnt_reg == IDX_W'(N_SERVERS - 1));
    assign arr_hit  = (arr_timer_reg == min_reg);
    assign time_sum = {1'b0, time_now_reg} + 65'(min_reg);
    assign time_sat = time_sum[64] ? '1 : time_sum[63:0];
    assign q_dec    = (head_qlen == '0) ? '0 : head_qlen - 1'b1;
    assign target   = mode_reg ? best_idx_reg : IDX_W'(rnd_mod);

    always_comb
    begin
        rnd_mod = {4'b0, rnd_reg};
        for (int k = 0; k < 7; k++)
        begin
            if (rnd_mod >= 7'(N_SERVERS))
            begin
                rnd_mod = rnd_mod - 7'(N_SERVERS);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        arr_timer_next = arr_timer_reg;
        time_now_next  = time_now_reg;
        arr_cnt_next   = arr_cnt_reg;
        dep_cnt_next   = dep_cnt_reg;
        a_int_next     = a_int_reg;
        s_time_next    = s_time_reg;
        rnd_next       = rnd_reg;
        min_next       = min_reg;
        best_q_next    = best_q_reg;
        best_idx_next  = best_idx_reg;
        sum_next       = sum_reg;
        dep_found_next = dep_found_reg;
        res_idx_next   = res_idx_reg;
        res_q_next     = res_q_reg;
        ovf_next       = ovf_reg;
        done_next      = 1'b0;
        kind_next      = kind_reg;
        sidx_next      = sidx_reg;
        elapsed_next   = elapsed_reg;
        simt_next      = simt_reg;
        sqlen_next     = sqlen_reg;
        total_next     = total_reg;
        arr_out_next   = arr_out_reg;
        dep_out_next   = dep_out_reg;
        qovf_next      = qovf_reg;
        ring_ctrl      = '0;
        fb_timer       = head_timer;
        fb_busy        = head_busy;
        fb_qlen        = head_qlen;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (op == OP_RESTART)
                    begin
                        ring_ctrl.clear = 1'b1;
                        arr_timer_next  = TB'(arrival_interval);
                        time_now_next   = '0;
                        arr_cnt_next    = '0;
                        dep_cnt_next    = '0;
                        kind_next       = KIND_RESTART;
                        sidx_next       = '0;
                        elapsed_next    = '0;
                        simt_next       = '0;
                        sqlen_next      = '0;
                        total_next      = '0;
                        arr_out_next    = '0;
                        dep_out_next    = '0;
                        qovf_next       = 1'b0;
                        done_next       = 1'b1;
                    end
                    else
                    begin
                        a_int_next  = TB'(arrival_interval);
                        s_time_next = TB'(service_time);
                        rnd_next    = random_server;
                        min_next    = arr_timer_reg;
                        sum_next    = '0;
                        cnt_next    = '0;
                        state_next  = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                ring_ctrl.shift = 1'b1;
                if (head_busy && (head_timer < min_reg))
                begin
                    min_next = head_timer;
                end
                if ((cnt_reg == '0) || (head_qlen < best_q_reg))
                begin
                    best_q_next   = head_qlen;
                    best_idx_next = cnt_reg;
                end
                sum_next = sum_reg + TOTAL_W'(head_qlen);
                if (last_pos)
                begin
                    cnt_next       = '0;
                    dep_found_next = 1'b0;
                    res_idx_next   = '0;
                    res_q_next     = '0;
                    ovf_next       = 1'b0;
                    state_next     = S_APPLY;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_APPLY:
            begin
                ring_ctrl.shift = 1'b1;
                fb_timer = head_busy ? head_timer - min_reg : head_timer;
                if (arr_hit)
                begin
                    if (cnt_reg == target)
                    begin
                        res_idx_next = cnt_reg;
                        if (head_qlen == '1)
                        begin
                            ovf_next   = 1'b1;
                            res_q_next = head_qlen;
                        end
                        else
                        begin
                            fb_qlen    = head_qlen + 1'b1;
                            res_q_next = head_qlen + 1'b1;
                            sum_next   = sum_reg + 1'b1;
                        end
                        if (!head_busy)
                        begin
                            fb_busy  = 1'b1;
                            fb_timer = s_time_reg;
                        end
                    end
                end
                else if (!dep_found_reg && head_busy && (head_timer == min_reg))
                begin
                    dep_found_next = 1'b1;
                    res_idx_next   = cnt_reg;
                    res_q_next     = q_dec;
                    fb_qlen        = q_dec;
                    if (head_qlen != '0)
                    begin
                        sum_next = sum_reg - 1'b1;
                    end
                    if (q_dec == '0)
                    begin
                        fb_busy  = 1'b0;
                        fb_timer = '0;
                    end
                    else
                    begin
                        fb_timer = s_time_reg;
                    end
                end
                if (last_pos)
                begin
                    cnt_next   = '0;
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_FIN:
            begin
                time_now_next = time_sat;
                if (arr_hit)
                begin
                    arr_timer_next = a_int_reg;
                    if (arr_cnt_reg != '1)
                    begin
                        arr_cnt_next = arr_cnt_reg + 1'b1;
                    end
                    kind_next = KIND_ARRIVAL;
                end
                else
                begin
                    arr_timer_next = arr_timer_reg - min_reg;
                    if (dep_cnt_reg != '1)
                    begin
                        dep_cnt_next = dep_cnt_reg + 1'b1;
                    end
                    kind_next = KIND_DEPARTURE;
                end
                sidx_next    = 3'(res_idx_reg);
                elapsed_next = 32'(min_reg);
                simt_next    = time_sat;
                sqlen_next   = 16'(res_q_reg);
                total_next   = sum_reg;
                arr_out_next = arr_cnt_next;
                dep_out_next = dep_cnt_next;
                qovf_next    = ovf_reg;
                done_next    = 1'b1;
                state_next   = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            mode_reg      <= 1'b0;
            arr_timer_reg <= '0;
            time_now_reg  <= '0;
            arr_cnt_reg   <= '0;
            dep_cnt_reg   <= '0;
            a_int_reg     <= '0;
            s_time_reg    <= '0;
            rnd_reg       <= '0;
            min_reg       <= '0;
            best_q_reg    <= '0;
            best_idx_reg  <= '0;
            sum_reg       <= '0;
            dep_found_reg <= 1'b0;
            res_idx_reg   <= '0;
            res_q_reg     <= '0;
            ovf_reg       <= 1'b0;
            done_reg      <= 1'b0;
            kind_reg      <= '0;
            sidx_reg      <= '0;
            elapsed_reg   <= '0;
            simt_reg      <= '0;
            sqlen_reg     <= '0;
            total_reg     <= '0;
            arr_out_reg   <= '0;
            dep_out_reg   <= '0;
            qovf_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            arr_timer_reg <= arr_timer_next;
            time_now_reg  <= time_now_next;
            arr_cnt_reg   <= arr_cnt_next;
            dep_cnt_reg   <= dep_cnt_next;
            a_int_reg     <= a_int_next;
            s_time_reg    <= s_time_next;
            rnd_reg       <= rnd_next;
            min_reg       <= min_next;
            best_q_reg    <= best_q_next;
            best_idx_reg  <= best_idx_next;
            sum_reg       <= sum_next;
            dep_found_reg <= dep_found_next;
            res_idx_reg   <= res_idx_next;
            res_q_reg     <= res_q_next;
            ovf_reg       <= ovf_next;
            done_reg      <= done_next;
            kind_reg      <= kind_next;
            sidx_reg      <= sidx_next;
            elapsed_reg   <= elapsed_next;
            simt_reg      <= simt_next;
            sqlen_reg     <= sqlen_next;
            total_reg     <= total_next;
            arr_out_reg   <= arr_out_next;
            dep_out_reg   <= dep_out_next;
            qovf_reg      <= qovf_next;
        end
    end

    assign busy                = (state_reg != S_IDLE);
    assign done                = done_reg;
    assign event_kind          = kind_reg;
    assign server_id           = sidx_reg;
    assign elapsed_step        = elapsed_reg;
    assign sim_time            = simt_reg;
    assign server_queue_length = sqlen_reg;
    assign total_waiting       = total_reg;
    assign arrivals_total      = arr_out_reg;
    assign departures_total    = dep_out_reg;
    assign queue_overflow      = qovf_reg;

`include "multi_server_queue_event_step_core_assert.svh"

    `MSQES_ASSERT_NOW(a_done_idle, done, !busy, "result strobed while busy")
    `MSQES_ASSERT_NEXT(a_start_moves, start && !busy, busy || done,
        "accepted command neither started nor finished")
    `MSQES_ASSERT_NOW(a_dep_no_ovf, done && (event_kind == KIND_DEPARTURE),
        !queue_overflow, "overflow flagged on departure")
    `MSQES_ASSERT_NOW(a_restart_zero, done && (event_kind == KIND_RESTART),
        (sim_time == '0) && (arrivals_total == '0) && (total_waiting == '0),
        "restart result not cleared")

endmodule

`default_nettype wire
